/* rtl/core/pagerank_power_iteration_macros.svh */
// ---------------------------------------------------------------------------
// PageRank assertion macros
// Short forms for the clocked implications used by the checker.
// ---------------------------------------------------------------------------
`ifndef PAGERANK_POWER_ITERATION_MACROS_SVH
`define PAGERANK_POWER_ITERATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRI_IMPLIES(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRI_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

/* rtl/core/pri_pkg.sv */
// ---------------------------------------------------------------------------
// PageRank package
// Types, constants and state codes shared by the block and its checker.
// ---------------------------------------------------------------------------
package pri_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CountW      = VtxW + 1;
  localparam int unsigned AccW        = 38;
  localparam logic [31:0] OneQ31      = 32'h8000_0000;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_VERTEX_COUNT  = 2'd0,
    REG_HOP_CHANCE    = 2'd1,
    REG_TOLERANCE     = 2'd2,
    REG_ITERATION_CAP = 2'd3
  } reg_idx_t;

  // Request mode codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [VtxW-1:0] vertex;
    logic [VtxW-1:0] first_target;
    logic [VtxW-1:0] second_target;
  } req_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex_id;
    logic [31:0]     rank;
    logic            converged;
    logic            last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_HOP,
    ST_DIV_ONE,
    ST_INIT,
    ST_MUL,
    ST_ADD1,
    ST_ADD2,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

/* rtl/core/pagerank_power_iteration.sv */
// ---------------------------------------------------------------------------
// PageRank power iteration
// A load request stores the two outgoing edges of one vertex; busy stays
// low, so loads may come every cycle while the block is idle. A run request
// does two divides through one shared radix-2 divider, then a setup pass,
// then iterations (one multiply and two accumulator updates per vertex, then
// one compare-and-sum pass per vertex), then one result per vertex, each
// shown for a single cycle with result_valid. The receiver cannot stall and
// must take every result.
// ---------------------------------------------------------------------------
module pagerank_power_iteration (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pri_pkg::req_t      request,
  output logic               result_valid,
  output pri_pkg::res_t      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pri_pkg::*;

  // Configuration registers.
  logic [5:0]  vertex_count;
  logic [31:0] hop_chance;
  logic [31:0] tolerance;
  logic [15:0] iteration_cap;

  // Working storage.
  logic [2*VtxW-1:0] edge_table [MaxVertices];
  logic [31:0]       current_rank [MaxVertices];
  logic [AccW-1:0]   acc [MaxVertices];

  state_t state, state_next;

  logic [VtxW-1:0] idx;
  logic [4:0]      div_cnt;
  logic [31:0]     div_q;
  logic [6:0]      div_r;
  logic [31:0]     base;
  logic [31:0]     one_n;
  logic [31:0]     share;
  logic [VtxW-1:0] tgt1, tgt2;
  logic [AccW-1:0] diff;
  logic [15:0]     iteration_count;
  logic            converged;

  // Derived run settings.
  logic [CountW-1:0] n;
  logic [VtxW-1:0]   n_m1;
  logic [31:0]       hop;
  logic [31:0]       keep;
  logic [15:0]       cap;
  logic              idx_last;
  logic              wr_cfg;
  reg_idx_t          wr_idx;

  always_comb begin
    n = vertex_count;
    if (vertex_count == '0) begin
      n = CountW'(1);
    end else if (vertex_count > CountW'(MaxVertices)) begin
      n = CountW'(MaxVertices);
    end
    n_m1     = VtxW'(n - CountW'(1));
    hop      = (hop_chance > OneQ31) ? OneQ31 : hop_chance;
    keep     = OneQ31 - hop;
    cap      = (iteration_cap == '0) ? 16'd1 : iteration_cap;
    idx_last = (idx == n_m1);
  end

  // Shared divider step: one quotient bit per cycle.
  logic [6:0] div_trial;
  logic       div_fit;
  logic [6:0] div_r_next;
  always_comb begin
    div_trial  = {div_r[5:0], div_q[31]};
    div_fit    = (div_trial >= 7'(n));
    div_r_next = div_fit ? (div_trial - 7'(n)) : div_trial;
  end

  // Accumulator update and the change sum.
  logic [VtxW-1:0] add_tgt;
  logic [AccW-1:0] add_val;
  logic [31:0]     sat_rank;
  logic [31:0]     abs_chg;
  logic [AccW-1:0] diff_sum;
  always_comb begin
    add_tgt  = (state == ST_ADD1) ? tgt1 : tgt2;
    add_val  = acc[add_tgt] + AccW'(share);
    sat_rank = (acc[idx] > AccW'(OneQ31)) ? OneQ31 : acc[idx][31:0];
    abs_chg  = (sat_rank >= current_rank[idx]) ? (sat_rank - current_rank[idx])
                                               : (current_rank[idx] - sat_rank);
    diff_sum = diff + AccW'(abs_chg);
  end

  logic iter_done, iter_ok;
  assign iter_ok   = (diff_sum <= AccW'(tolerance));
  assign iter_done = iter_ok || ((iteration_count + 16'd1) >= cap);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && request.mode == MODE_RUN) state_next = ST_DIV_HOP;
      end
      ST_DIV_HOP: begin
        if (div_cnt == '1) state_next = ST_DIV_ONE;
      end
      ST_DIV_ONE: begin
        if (div_cnt == '1) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (idx_last) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_ADD1;
      ST_ADD1: state_next = ST_ADD2;
      ST_ADD2: state_next = idx_last ? ST_SUM : ST_MUL;
      ST_SUM: begin
        if (idx_last) state_next = iter_done ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (idx_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx             <= '0;
      div_cnt         <= '0;
      iteration_count <= '0;
      converged       <= 1'b0;
      diff            <= '0;
    end else begin
      case (state) inside
        ST_IDLE: begin
          idx     <= '0;
          div_cnt <= '0;
          if (start && request.mode == MODE_RUN) iteration_count <= '0;
        end
        ST_DIV_HOP, ST_DIV_ONE: div_cnt <= div_cnt + 5'd1;
        ST_INIT: begin
          idx  <= idx_last ? '0 : idx + VtxW'(1);
          diff <= '0;
        end
        ST_ADD2: idx <= idx_last ? '0 : idx + VtxW'(1);
        ST_SUM: begin
          idx  <= idx_last ? '0 : idx + VtxW'(1);
          diff <= idx_last ? '0 : diff_sum;
          if (idx_last) begin
            iteration_count <= iteration_count + 16'd1;
            converged       <= iter_ok;
          end
        end
        ST_OUT: idx <= idx_last ? '0 : idx + VtxW'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state) inside
      ST_IDLE: begin
        if (start && request.mode == MODE_LOAD) begin
          edge_table[request.vertex] <= {request.first_target, request.second_target};
        end
        div_q <= hop;
        div_r <= '0;
      end
      ST_DIV_HOP: begin
        div_q <= {div_q[30:0], div_fit};
        div_r <= div_r_next;
        if (div_cnt == '1) begin
          base  <= {div_q[30:0], div_fit};
          div_q <= OneQ31;
          div_r <= '0;
        end
      end
      ST_DIV_ONE: begin
        div_q <= {div_q[30:0], div_fit};
        div_r <= div_r_next;
        if (div_cnt == '1) one_n <= {div_q[30:0], div_fit};
      end
      ST_INIT: begin
        current_rank[idx] <= one_n;
        acc[idx]          <= AccW'(base);
      end
      ST_MUL: begin
        share <= 32'((64'(keep) * 64'(current_rank[idx])) >> 32);
        tgt1  <= edge_table[idx][2*VtxW-1:VtxW];
        tgt2  <= edge_table[idx][VtxW-1:0];
      end
      ST_ADD1, ST_ADD2: begin
        if (CountW'(add_tgt) < n) acc[add_tgt] <= add_val;
      end
      ST_SUM: begin
        current_rank[idx] <= sat_rank;
        acc[idx]          <= AccW'(base);
      end
      default: ;
    endcase
  end

  // Configuration port.
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= 6'd5;
      hop_chance    <= 32'd322122547;
      tolerance     <= 32'd107;
      iteration_cap <= 16'd1000;
    end else if (wr_cfg) begin
      unique case (wr_idx)
        REG_VERTEX_COUNT:  vertex_count  <= pwdata[5:0];
        REG_HOP_CHANCE:    hop_chance    <= pwdata;
        REG_TOLERANCE:     tolerance     <= pwdata;
        REG_ITERATION_CAP: iteration_cap <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_VERTEX_COUNT:  prdata = {26'd0, vertex_count};
      REG_HOP_CHANCE:    prdata = hop_chance;
      REG_TOLERANCE:     prdata = tolerance;
      REG_ITERATION_CAP: prdata = {16'd0, iteration_cap};
      default:           prdata = '0;
    endcase
  end

  // Handshake and result.
  assign busy                = (state != ST_IDLE);
  assign result_valid        = (state == ST_OUT);
  assign result.vertex_id    = idx;
  assign result.rank         = current_rank[idx];
  assign result.converged    = converged;
  assign result.last         = idx_last;

endmodule

/* rtl/core/pri_checker.sv */
// ---------------------------------------------------------------------------
// PageRank port checker
// Watches the ports of the block for ordering of requests and results.
// ---------------------------------------------------------------------------
`include "pagerank_power_iteration_macros.svh"

module pri_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input pri_pkg::req_t request,
  input logic          result_valid,
  input pri_pkg::res_t result
);
  import pri_pkg::*;

  // Results only appear while a run is in progress.
  `PRI_IMPLIES(a_res_busy, result_valid, busy, "result outside a run")
  // A run request makes the block busy.
  `PRI_NEXT(a_run_busy, start && !busy && request.mode == MODE_RUN, busy, "run not started")
  // Results run without gaps, vertex ids counting up.
  `PRI_NEXT(a_res_seq, result_valid && !result.last, result_valid && result.vertex_id == VtxW'($past(result.vertex_id) + VtxW'(1)), "result gap")
  // The last result ends the burst.
  `PRI_NEXT(a_res_end, result_valid && result.last, !result_valid && !busy, "results after last")

endmodule

bind pagerank_power_iteration pri_checker u_pri_checker (.*);

/* sim/pagerank_power_iteration_checker.sv */
// ---------------------------------------------------------------------------
// PageRank power iteration checker
// Watches the configuration port, the request channel and the result strobe.
// It keeps its own copy of the registers and the edge table and works out
// the ranks of every run. Each strobed result is compared field by field
// with the oldest rank it is still waiting for.
// ---------------------------------------------------------------------------
module pagerank_power_iteration_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  pri_pkg::req_t request,
  input  logic          result_valid,
  input  pri_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  output int            fail_count,
  output int            pending
);
  import pri_pkg::*;

  localparam longint unsigned OneQ = 64'h8000_0000;

  // Shadow copy of the registers and of the edge table.
  logic [5:0]  vertex_count_q;
  logic [31:0] hop_chance_q;
  logic [31:0] tolerance_q;
  logic [15:0] iteration_cap_q;
  logic [9:0]  links [MaxVertices];

  res_t expected_ranks [$];

  assign pending = expected_ranks.size();

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("rank result %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Work out the final ranks of one run and queue one result per vertex.
  function automatic void predict_ranks();
    int unsigned n;
    int unsigned cap;
    int unsigned count;
    longint unsigned hop, base, keep, diff, share, nr, cr;
    longint unsigned rank_now [MaxVertices];
    longint unsigned acc [MaxVertices];
    logic [4:0] t1, t2;
    bit ok;
    res_t r;
    n = 32'(vertex_count_q);
    if (n == 0) n = 1;
    if (n > MaxVertices) n = MaxVertices;
    hop = (hop_chance_q > OneQ) ? OneQ : longint'(hop_chance_q);
    base = hop / n;
    keep = OneQ - hop;
    cap = (iteration_cap_q == 0) ? 1 : 32'(iteration_cap_q);
    for (int i = 0; i < n; i++) rank_now[i] = OneQ / n;
    count = 0;
    ok = 0;
    forever begin
      for (int i = 0; i < n; i++) acc[i] = base;
      for (int i = 0; i < n; i++) begin
        share = (keep * rank_now[i]) >> 32;
        t1 = links[i][9:5];
        t2 = links[i][4:0];
        // Shares aimed at vertices outside the graph are dropped.
        if (t1 < n) acc[t1] += share;
        if (t2 < n) acc[t2] += share;
      end
      diff = 0;
      for (int i = 0; i < n; i++) begin
        nr = (acc[i] > OneQ) ? OneQ : acc[i];
        cr = rank_now[i];
        diff += (nr >= cr) ? nr - cr : cr - nr;
        rank_now[i] = nr;
      end
      count++;
      if (diff <= tolerance_q) begin
        ok = 1;
        break;
      end
      if (count >= cap) break;
    end
    for (int i = 0; i < n; i++) begin
      r.vertex_id = i[4:0];
      r.rank      = rank_now[i][31:0];
      r.converged = ok;
      r.last      = (i + 1 == n);
      expected_ranks.push_back(r);
    end
  endfunction

  // Track register writes, requests and results at every edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      vertex_count_q  <= 6'd5;
      hop_chance_q    <= 32'd322122547;
      tolerance_q     <= 32'd107;
      iteration_cap_q <= 16'd1000;
      expected_ranks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_VERTEX_COUNT:  vertex_count_q  = pwdata[5:0];
          REG_HOP_CHANCE:    hop_chance_q    = pwdata;
          REG_TOLERANCE:     tolerance_q     = pwdata;
          REG_ITERATION_CAP: iteration_cap_q = pwdata[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (request.mode == MODE_LOAD)
          links[request.vertex] = {request.first_target, request.second_target};
        else
          predict_ranks();
      end
      if (result_valid) begin
        if (expected_ranks.size() == 0) begin
          $display("rank result for vertex %0d arrived with none expected",
                   result.vertex_id);
          fail_count++;
        end else begin
          want = expected_ranks.pop_front();
          if (result.vertex_id !== want.vertex_id)
            report("vertex_id", result.vertex_id, want.vertex_id);
          if (result.rank !== want.rank)
            report("rank", result.rank, want.rank);
          if (result.converged !== want.converged)
            report("converged", result.converged, want.converged);
          if (result.last !== want.last)
            report("last", result.last, want.last);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

/* sim/pagerank_power_iteration_tb.sv */
// ---------------------------------------------------------------------------
// PageRank power iteration testbench
// Loads edge tables, runs power iterations under many register settings and
// lets the checker compare every reported rank with its own prediction.
// ---------------------------------------------------------------------------
module pagerank_power_iteration_tb;
  import pri_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int ItemTarget = 270;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        result_valid;
  res_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int          cycles;
  int          loads_sent;
  int          runs_sent;
  int          settings_used;
  int          active_n;
  bit          loaded [MaxVertices];

  pagerank_power_iteration DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  pagerank_power_iteration_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("pagerank_power_iteration: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Write one register through a setup and an access cycle. The port is
  // left selected so that writes can follow back to back.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_VERTEX_COUNT) begin
      active_n = int'(value[5:0]);
      if (active_n == 0) active_n = 1;
      if (active_n > MaxVertices) active_n = MaxVertices;
    end
  endtask

  // Hold a request until the block takes it, then leave a random gap.
  task automatic send(input req_t r);
    int gap;
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.mode == MODE_LOAD) begin
      loads_sent++;
      loaded[r.vertex] = 1'b1;
    end else begin
      runs_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_edges(input int v, input int a, input int b);
    req_t r;
    r.mode          = MODE_LOAD;
    r.vertex        = v[4:0];
    r.first_target  = a[4:0];
    r.second_target = b[4:0];
    send(r);
  endtask

  // Fill any edge entry the run would read before it was loaded, then run.
  task automatic run_ranks();
    req_t r;
    for (int v = 0; v < active_n; v++)
      if (!loaded[v]) load_edges(v, $urandom_range(0, 31), $urandom_range(0, 31));
    r = req_t'(16'($urandom));
    r.mode = MODE_RUN;
    send(r);
  endtask

  // Let every expected rank arrive and the block fall quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] nv, input logic [31:0] hop,
                            input logic [31:0] tol, input logic [31:0] cap);
    drain();
    reg_write(REG_VERTEX_COUNT, nv);
    reg_write(REG_HOP_CHANCE, hop);
    reg_write(REG_TOLERANCE, tol);
    reg_write(REG_ITERATION_CAP, cap);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [31:0] nv, hop, tol, cap;
    int burst;
    cycles        = 0;
    loads_sent    = 0;
    runs_sent     = 0;
    settings_used = 1;
    active_n      = 5;
    for (int v = 0; v < MaxVertices; v++) loaded[v] = 1'b0;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: reset settings first, targets at both ends and
    // targets beyond the graph so that their shares are dropped.
    load_edges(0, 0, 31);
    load_edges(1, 31, 0);
    load_edges(2, 2, 2);
    load_edges(3, 4, 1);
    load_edges(4, 0, 0);
    run_ranks();
    // A vertex count of zero behaves as a single vertex.
    set_config(0, 32'd322122547, 107, 20);
    run_ranks();
    // A zero cap still does one iteration; zero tolerance converges only when the ranks stop changing.
    set_config(5, 32'd322122547, 0, 0);
    run_ranks();
    // A hop chance above one is clipped to one.
    set_config(3, 32'hFFFF_FFFF, 0, 65535);
    run_ranks();
    set_config(4, 0, 0, 12);
    run_ranks();
    set_config(5, 32'h8000_0000, 32'h8000_0000, 65535);
    run_ranks();
    // A vertex count above the table size uses the whole table.
    set_config(63, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8);
    run_ranks();

    // Random part: new settings, a burst of loads, then one or two runs.
    while (loads_sent + runs_sent < ItemTarget) begin
      nv  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
      hop = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom & 32'h7FFF_FFFF);
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = $urandom_range(0, 2000);
        2: tol = $urandom_range(0, 2000000);
        default: tol = $urandom;
      endcase
      cap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 25);
      set_config(nv, hop, tol, cap);
      burst = $urandom_range(0, 14);
      repeat (burst)
        load_edges($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      run_ranks();
      if ($urandom_range(0, 2) == 0) run_ranks();
    end

    drain();
    $display("covered %0d edge loads and %0d runs under %0d register settings",
             loads_sent, runs_sent, settings_used);
    if (fail_count == 0) begin
      $display("pagerank_power_iteration: match");
    end else begin
      $display("pagerank_power_iteration: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/pri_pkg.sv
rtl/core/pagerank_power_iteration.sv
rtl/core/pri_checker.sv
sim/pagerank_power_iteration_checker.sv
sim/pagerank_power_iteration_tb.sv
